/* hw/rtl/stpf_pkg.sv */
// Package for the serial-tagged packet FIFO.
// Request and status codes, entry layout, phase type and defaults.
// No dependencies.
`default_nettype none
package stpf_pkg;

	localparam int DEPTH_DEF    = 64;
	localparam int OVERHEAD_DEF = 32;

	localparam int HANDLE_W = 32;
	localparam int SIZE_W   = 24;
	localparam int DUR_W    = 32;
	localparam int SERIAL_W = 32;
	localparam int BYTES_W  = 32;
	localparam int DTOT_W   = 38;

	localparam logic [2:0] REQ_PUT   = 3'd0;
	localparam logic [2:0] REQ_GET   = 3'd1;
	localparam logic [2:0] REQ_FLUSH = 3'd2;
	localparam logic [2:0] REQ_ABORT = 3'd3;
	localparam logic [2:0] REQ_START = 3'd4;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_EMPTY = 2'd1,
		STS_ABORT = 2'd2,
		STS_FULL  = 2'd3
	} sts_t;

	typedef enum logic {
		PH_IDLE,
		PH_EXEC
	} phase_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [SIZE_W-1:0]   size;
		logic [DUR_W-1:0]    duration;
		logic                marker;
		logic [SERIAL_W-1:0] serial;
	} entry_t;

endpackage
`default_nettype wire

/* hw/rtl/serial_tagged_packet_fifo.sv */
// Serial-tagged packet descriptor FIFO, top level.
// Holds the descriptor memory, pointers, totals and request sequencer.
// Depends on stpf_pkg.
//
// Each request is handled by the phase sequencer: the accept in the idle phase
// issues the read of the head entry from the single-port-read descriptor memory,
// and the exec phase applies the request (write at tail, pointer, count and total
// updates) and loads the result register. A new request is accepted only in the
// idle phase, after the last one has committed; a waiting result holds the exec phase.
// Memory contents are not cleared; only entries that were put are read.
`default_nettype none
module serial_tagged_packet_fifo #(
	parameter int DEPTH          = stpf_pkg::DEPTH_DEF,
	parameter int ENTRY_OVERHEAD = stpf_pkg::OVERHEAD_DEF,
	localparam int CNT_W         = $clog2(DEPTH + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire logic [2:0]                    req_type,
	input  wire logic                          is_marker,
	input  wire logic [stpf_pkg::HANDLE_W-1:0] pkt_handle,
	input  wire logic [stpf_pkg::SIZE_W-1:0]   pkt_size,
	input  wire logic [stpf_pkg::DUR_W-1:0]    pkt_duration,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	output logic [1:0]                         status,
	output logic [stpf_pkg::HANDLE_W-1:0]      out_handle,
	output logic [stpf_pkg::SIZE_W-1:0]        out_size,
	output logic [stpf_pkg::DUR_W-1:0]         out_duration,
	output logic                               out_is_marker,
	output logic [stpf_pkg::SERIAL_W-1:0]      out_serial,
	output logic [CNT_W-1:0]                   queued_count,
	output logic [stpf_pkg::BYTES_W-1:0]       queued_bytes,
	output logic [stpf_pkg::DTOT_W-1:0]        queued_duration
);
	import stpf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
	localparam logic [BYTES_W-1:0] OVH     = BYTES_W'(ENTRY_OVERHEAD);

	entry_t mem [DEPTH];
	entry_t rd_s1;

	phase_t ph_q, ph_d;

	logic [2:0]          req_q;
	logic                marker_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [SIZE_W-1:0]   size_q;
	logic [DUR_W-1:0]    dur_q;

	logic [PTR_W-1:0]    head_q, tail_q, head_d, tail_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [BYTES_W-1:0]  bytes_q, bytes_d;
	logic [DTOT_W-1:0]   dtot_q, dtot_d;
	logic [SERIAL_W-1:0] serial_q, serial_d;
	logic                abort_q, abort_d;

	logic                rsp_valid_q;
	sts_t                sts_q, sts_d;
	entry_t              out_q, out_d;

	logic                accept, commit, wr_en;
	entry_t              wr_data;
	logic                put_req, put_abort, put_marker;

	assign accept = req_valid && req_ready;

	always_comb begin
		ph_d      = ph_q;
		req_ready = (ph_q == PH_IDLE);
		commit    = 1'b0;
		case (ph_q)
			PH_IDLE: begin
				if (req_valid) begin
					ph_d = PH_EXEC;
				end
			end
			PH_EXEC: begin
				if (!rsp_valid_q || rsp_ready) begin
					commit = 1'b1;
					ph_d   = PH_IDLE;
				end
			end
			default: ph_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
		end else begin
			ph_q <= ph_d;
		end
	end

	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		cnt_d      = cnt_q;
		bytes_d    = bytes_q;
		dtot_d     = dtot_q;
		serial_d   = serial_q;
		abort_d    = abort_q;
		sts_d      = STS_OK;
		out_d      = '0;
		wr_en      = 1'b0;
		put_req    = (req_q == REQ_PUT) || (req_q == REQ_START);
		put_abort  = (req_q == REQ_PUT) && abort_q;
		put_marker = (req_q == REQ_START) || marker_q;
		wr_data    = '0;
		if (req_q == REQ_PUT) begin
			wr_data.handle   = handle_q;
			wr_data.size     = size_q;
			wr_data.duration = dur_q;
		end
		wr_data.marker = put_marker;
		wr_data.serial = put_marker ? serial_q + 1'b1 : serial_q;

		if (put_req) begin
			if (req_q == REQ_START) begin
				abort_d = 1'b0;
			end
			if (put_abort) begin
				sts_d = STS_ABORT;
			end else if (cnt_q == FULL_CNT) begin
				sts_d = STS_FULL;
			end else begin
				wr_en    = 1'b1;
				serial_d = wr_data.serial;
				tail_d   = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
				cnt_d    = cnt_q + 1'b1;
				bytes_d  = bytes_q + BYTES_W'(wr_data.size) + OVH;
				dtot_d   = dtot_q + DTOT_W'(wr_data.duration);
			end
		end else begin
			case (req_q)
				REQ_GET: begin
					if (abort_q) begin
						sts_d = STS_ABORT;
					end else if (cnt_q == '0) begin
						sts_d = STS_EMPTY;
					end else begin
						out_d   = rd_s1;
						head_d  = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
						cnt_d   = cnt_q - 1'b1;
						bytes_d = bytes_q - BYTES_W'(rd_s1.size) - OVH;
						dtot_d  = dtot_q - DTOT_W'(rd_s1.duration);
					end
				end
				REQ_FLUSH: begin
					head_d  = '0;
					tail_d  = '0;
					cnt_d   = '0;
					bytes_d = '0;
					dtot_d  = '0;
				end
				REQ_ABORT: abort_d = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			bytes_q     <= '0;
			dtot_q      <= '0;
			serial_q    <= '0;
			abort_q     <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				head_q   <= head_d;
				tail_q   <= tail_d;
				cnt_q    <= cnt_d;
				bytes_q  <= bytes_d;
				dtot_q   <= dtot_d;
				serial_q <= serial_d;
				abort_q  <= abort_d;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= req_type;
			marker_q <= is_marker;
			handle_q <= pkt_handle;
			size_q   <= pkt_size;
			dur_q    <= pkt_duration;
		end
		if (commit) begin
			sts_q <= sts_d;
			out_q <= out_d;
		end
	end

	// descriptor memory: one write port at tail, one registered read at head
	always_ff @(posedge clk) begin
		if (commit && wr_en) begin
			mem[tail_q] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem[head_q];
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign status          = sts_q;
	assign out_handle      = out_q.handle;
	assign out_size        = out_q.size;
	assign out_duration    = out_q.duration;
	assign out_is_marker   = out_q.marker;
	assign out_serial      = out_q.serial;
	assign queued_count    = cnt_q;
	assign queued_bytes    = bytes_q;
	assign queued_duration = dtot_q;

endmodule
`default_nettype wire

/* hw/rtl/stpf_checker.sv */
// Port-level checker for the serial-tagged packet FIFO, with its bind.
// Depends on stpf_pkg and serial_tagged_packet_fifo.
`default_nettype none
module stpf_checker #(
	parameter int DEPTH  = stpf_pkg::DEPTH_DEF,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [1:0]                    status,
	input wire logic [stpf_pkg::HANDLE_W-1:0] out_handle,
	input wire logic [stpf_pkg::SERIAL_W-1:0] out_serial,
	input wire logic [CNT_W-1:0]              queued_count
);
	import stpf_pkg::*;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(queued_count))
		else $error("result beat changed while stalled");

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> queued_count <= FULL_CNT)
		else $error("entry count above depth");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STS_EMPTY |-> queued_count == '0)
		else $error("empty status with entries held");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STS_FULL |-> queued_count == FULL_CNT)
		else $error("full status with free slots");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != STS_OK |-> out_handle == '0 && out_serial == '0)
		else $error("entry fields set on failed request");

endmodule

bind serial_tagged_packet_fifo stpf_checker #(.DEPTH(DEPTH)) u_stpf_checker (.*);
`default_nettype wire
